@@ rtl/core/config_key_line_finder_defines.svh @@
// Assertion macros shared by the key line finder RTL.
`ifndef CONFIG_KEY_LINE_FINDER_DEFINES_SVH
`define CONFIG_KEY_LINE_FINDER_DEFINES_SVH

`ifndef SYNTH
`define CKLF_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cklf check failed");
`define CKLF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cklf check failed");
`else
`define CKLF_ASSERT_HOLDS(label, clk, rst_n, ante, cons)
`define CKLF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/cklf_pkg.sv @@
package cklf_pkg;

    localparam int KEY_MAX      = 16;
    localparam int KEY_IDX_BITS = $clog2(KEY_MAX);
    localparam int KEY_CNT_BITS = $clog2(KEY_MAX + 1);
    localparam int POS_BITS     = 16;
    localparam int CFG_BITS     = 64;
    localparam int CFG_IDX_BITS = 2;
    localparam int KEY_LEN_BITS = 4;

    typedef logic [POS_BITS-1:0] t_pos;
    typedef logic [7:0]          t_char;

    localparam t_pos POS_MAX = '1;

    localparam logic [CFG_IDX_BITS-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_KEY_LEN  = 2'd2;

    localparam t_char CH_NUL    = 8'd0;
    localparam t_char CH_TAB    = 8'd9;
    localparam t_char CH_LF     = 8'd10;
    localparam t_char CH_CR     = 8'd13;
    localparam t_char CH_SPACE  = 8'h20;
    localparam t_char CH_HASH   = 8'h23;
    localparam t_char CH_EQUAL  = 8'h3d;
    localparam t_char CH_USCORE = 8'h5f;

    typedef enum logic [2:0] {
        SCAN_SEARCH = 3'b001,
        SCAN_SKIP   = 3'b010,
        SCAN_VALUE  = 3'b100
    } t_scan_mode;

    typedef enum logic [2:0] {
        PH_START = 3'b001,
        PH_WORD  = 3'b010,
        PH_AFTER = 3'b100
    } t_phase;

    typedef struct packed {
        logic [KEY_MAX-1:0][7:0]  chars;
        logic [KEY_CNT_BITS-1:0]  len;
    } t_pattern;

    typedef struct packed {
        logic found;
        t_pos key_offset;
        t_pos value_offset;
        t_pos value_length;
        logic stream_done;
    } t_result;

    function automatic t_char fold(input t_char c);
        t_char r;
        r = c;
        if (c inside {[8'h41:8'h5a]}) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/cklf_in_if.sv @@
interface cklf_in_if;
    import cklf_pkg::*;

    logic  valid;
    logic  ready;
    t_char text_byte;
    logic  final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

@@ rtl/core/cklf_out_if.sv @@
interface cklf_out_if;
    import cklf_pkg::*;

    logic valid;
    logic ready;
    logic found;
    t_pos key_offset;
    t_pos value_offset;
    t_pos value_length;
    logic stream_done;

    modport source (
        output valid, output found, output key_offset, output value_offset,
        output value_length, output stream_done, input ready
    );
    modport sink (
        input valid, input found, input key_offset, input value_offset,
        input value_length, input stream_done, output ready
    );
endinterface

@@ rtl/core/cklf_cfg_regs.sv @@
module cklf_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [cklf_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [cklf_pkg::CFG_BITS-1:0]      i_cfg_data,
    output cklf_pkg::t_pattern                 o_pattern
);
    import cklf_pkg::*;

    logic [CFG_BITS-1:0]     r_key_low;
    logic [CFG_BITS-1:0]     r_key_high;
    logic [KEY_LEN_BITS-1:0] r_key_len;

    logic [KEY_MAX-1:0][7:0]  key;
    logic [KEY_IDX_BITS-1:0]  k;
    t_char                    last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= KEY_LEN_BITS'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                REG_KEY_LEN:  r_key_len  <= i_cfg_data[KEY_LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamp length to at least one character; pad past it with a space
    always_comb begin
        key  = {r_key_high, r_key_low};
        k    = (r_key_len == '0) ? KEY_IDX_BITS'(1) : r_key_len;
        last = fold(key[k - KEY_IDX_BITS'(1)]);
        for (int i = 0; i < KEY_MAX; i++) begin
            o_pattern.chars[i] = (KEY_IDX_BITS'(i) < k) ? fold(key[i]) : CH_SPACE;
        end
        o_pattern.len = KEY_CNT_BITS'(k) + KEY_CNT_BITS'(last != CH_SPACE);
    end

endmodule

@@ rtl/core/cklf_scan_core.sv @@
`include "config_key_line_finder_defines.svh"

module cklf_scan_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  cklf_pkg::t_char    i_text_byte,
    input  logic               i_final_byte,
    input  cklf_pkg::t_pattern i_pattern,
    output logic               o_push,
    output cklf_pkg::t_result  o_result
);
    import cklf_pkg::*;

    t_pos                    r_pos;
    logic [KEY_CNT_BITS-1:0] r_mc;
    t_phase                  r_phase;
    logic                    r_ic;
    t_scan_mode              r_mode;
    t_pos                    r_kstart;
    t_pos                    r_vstart;

    t_pos                    n_pos;
    logic [KEY_CNT_BITS-1:0] n_mc;
    t_phase                  n_phase;
    logic                    n_ic;
    t_scan_mode              n_mode;
    t_pos                    n_kstart;
    t_pos                    n_vstart;

    logic    line_end;
    logic    blank;
    logic    word;
    logic    ok;
    t_char   c;
    t_result res;

    always_comb begin
        c        = i_text_byte;
        line_end = (c == CH_LF) || (c == CH_CR) || (c == CH_NUL);
        blank    = (c == CH_SPACE) || (c == CH_TAB);
        word     = (c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]}) ||
                   (c == CH_USCORE);
        n_pos    = (r_pos != POS_MAX) ? r_pos + POS_BITS'(1) : POS_MAX;
        n_mc     = r_mc;
        n_phase  = r_phase;
        n_ic     = r_ic;
        n_mode   = r_mode;
        n_kstart = r_kstart;
        n_vstart = r_vstart;
        ok       = 1'b0;
        res      = '0;

        if (n_mode == SCAN_SKIP && !(blank || c == CH_EQUAL)) begin
            n_vstart = r_pos;
            n_mode   = SCAN_VALUE;
        end
        if (n_mode == SCAN_VALUE && line_end) begin
            res.found        = 1'b1;
            res.key_offset   = r_kstart;
            res.value_offset = n_vstart;
            res.value_length = (r_pos >= n_vstart) ? r_pos - n_vstart : '0;
            n_mode           = SCAN_SEARCH;
        end

        if (n_mode == SCAN_SEARCH) begin
            if (c == CH_HASH) begin
                n_ic = 1'b1;
            end
            if (line_end) begin
                n_ic    = 1'b0;
                n_phase = PH_START;
                n_mc    = '0;
            end else if (!n_ic) begin
                ok = (n_mc < i_pattern.len) &&
                     (fold(c) == i_pattern.chars[n_mc[KEY_IDX_BITS-1:0]]) &&
                     ((n_mc == '0 && n_phase == PH_START) ||
                      (n_mc != '0 && n_phase == PH_WORD));
                if (ok) begin
                    if (n_mc == '0) begin
                        n_kstart = r_pos;
                    end
                    n_mc = n_mc + KEY_CNT_BITS'(1);
                end else begin
                    n_mc = '0;
                end
                if (word && n_phase == PH_START) begin
                    n_phase = PH_WORD;
                end
                if (blank && n_phase == PH_WORD) begin
                    n_phase = PH_AFTER;
                end
                if (n_mc >= i_pattern.len) begin
                    n_mc   = '0;
                    n_mode = SCAN_SKIP;
                end
            end
        end

        // close an open key line at the end of the text
        if (i_final_byte) begin
            if (n_mode == SCAN_SKIP) begin
                res.found        = 1'b1;
                res.key_offset   = n_kstart;
                res.value_offset = n_pos;
                res.value_length = '0;
            end else if (n_mode == SCAN_VALUE) begin
                res.found        = 1'b1;
                res.key_offset   = n_kstart;
                res.value_offset = n_vstart;
                res.value_length = (n_pos >= n_vstart) ? n_pos - n_vstart : '0;
            end
        end
        res.stream_done = i_final_byte;
    end

    assign o_result = res;
    assign o_push   = i_fire && (res.found || i_final_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_final_byte)) begin
            r_pos    <= '0;
            r_mc     <= '0;
            r_phase  <= PH_START;
            r_ic     <= 1'b0;
            r_mode   <= SCAN_SEARCH;
            r_kstart <= '0;
            r_vstart <= '0;
        end else if (i_fire) begin
            r_pos    <= n_pos;
            r_mc     <= n_mc;
            r_phase  <= n_phase;
            r_ic     <= n_ic;
            r_mode   <= n_mode;
            r_kstart <= n_kstart;
            r_vstart <= n_vstart;
        end
    end

    `CKLF_ASSERT_NEXT(a_final_clears, i_clk, i_rst_n, i_fire && i_final_byte, r_pos == '0 && r_mode == SCAN_SEARCH)
    `CKLF_ASSERT_NEXT(a_pos_step, i_clk, i_rst_n, i_fire && !i_final_byte && r_pos != POS_MAX, r_pos == $past(r_pos) + POS_BITS'(1))
    `CKLF_ASSERT_HOLDS(a_empty_is_done, i_clk, i_rst_n, o_push && !o_result.found, o_result.stream_done)

endmodule

@@ rtl/core/cklf_out_buf.sv @@
`include "config_key_line_finder_defines.svh"

module cklf_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cklf_pkg::t_result i_result,
    output logic              o_full,
    cklf_out_if.source        o_match
);
    import cklf_pkg::*;

    t_result    r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    logic    pop;
    t_result head;

    assign head    = r_mem[r_rd];
    assign pop     = o_match.valid && o_match.ready;
    assign o_full  = (r_count == 2'd2);

    assign o_match.valid        = (r_count != 2'd0);
    assign o_match.found        = head.found;
    assign o_match.key_offset   = head.key_offset;
    assign o_match.value_offset = head.value_offset;
    assign o_match.value_length = head.value_length;
    assign o_match.stream_done  = head.stream_done;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    `CKLF_ASSERT_HOLDS(a_no_overflow, i_clk, i_rst_n, i_push, r_count != 2'd2)

endmodule

@@ rtl/core/config_key_line_finder.sv @@
// Key line finder for configuration text.
// Input channel i_text carries one text byte per beat with final_byte marking
// the last byte of a text. Output channel o_match carries result beats: a
// found line (key offset, value offset, value length) when a value line ends,
// and one beat with stream_done on the final byte of each text.
// The key is set through the write port (index 0 key bytes 0-7, index 1 key
// bytes 8-15, index 2 key length); the user must do so only while no text is in
// flight, which the block itself does not enforce. A byte is registered in the
// input register on acceptance; its result, if any, is written into the output
// buffer when the byte leaves that register and is then presented on o_match.
// Throughput: one byte per cycle while the output buffer is not full; the scan
// state updates from a single byte with compares and one position increment.
// Reset clears the scan state, the output buffer and the key registers (key
// length one); no clearing pass is needed.
// When the receiver stalls, the two-beat output buffer absorbs results; once
// it is full the input register holds its byte and i_text.ready drops.
module config_key_line_finder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [cklf_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [cklf_pkg::CFG_BITS-1:0]      i_cfg_data,
    cklf_in_if.sink                            i_text,
    cklf_out_if.source                         o_match
);
    import cklf_pkg::*;

    logic     r_s1_valid;
    t_char    r_s1_byte;
    logic     r_s1_final;

    logic     s1_fire;
    logic     in_fire;
    logic     buf_full;
    logic     push;
    t_result  result;
    t_pattern pattern;

    assign s1_fire      = r_s1_valid && !buf_full;
    assign i_text.ready = !r_s1_valid || !buf_full;
    assign in_fire      = i_text.valid && i_text.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_byte  <= i_text.text_byte;
            r_s1_final <= i_text.final_byte;
        end
    end

    cklf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pattern   (pattern)
    );

    cklf_scan_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (s1_fire),
        .i_text_byte  (r_s1_byte),
        .i_final_byte (r_s1_final),
        .i_pattern    (pattern),
        .o_push       (push),
        .o_result     (result)
    );

    cklf_out_buf u_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .o_full   (buf_full),
        .o_match  (o_match)
    );

endmodule
